// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check with active-low reset
`define RSFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rsfr port check failed");

// a stalled valid holds until taken
`define RSFR_ASSERT_HOLD(lbl, clk, rstn, vld, rdy) \
  `RSFR_ASSERT(lbl, clk, rstn, (vld) && !(rdy) |=> (vld))

`endif

// ===== src/rsfr_pkg.sv =====
`timescale 1ns / 1ps
package rsfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned TICK_W = 16;

  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd4;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_IDLE  = 2'd1;
  localparam logic [1:0] MODE_RECV  = 2'd2;
  localparam logic [1:0] MODE_ERROR = 2'd3;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } rsfr_mem_req_t;

endpackage

// ===== src/rsfr_store.sv =====
`timescale 1ns / 1ps
module rsfr_store #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                          clk_i,
  input  rsfr_pkg::rsfr_mem_req_t       req_i,
  output logic [rsfr_pkg::BYTE_W-1:0]   rdata_o
);
  import rsfr_pkg::*;

  localparam int unsigned AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  logic [BYTE_W-1:0] mem [FRAME_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rsfr_ctrl.sv =====
`timescale 1ns / 1ps
module rsfr_ctrl #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsfr_pkg::TICK_W-1:0]   cfg_silence_ticks_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [rsfr_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                          tx_busy_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rsfr_pkg::BYTE_W-1:0]   frame_byte_o,
  output logic [rsfr_pkg::IDX_W-1:0]    byte_index_o,
  output logic [rsfr_pkg::LEN_W-1:0]    frame_length_o,
  output logic                          frame_last_o,
  output rsfr_pkg::rsfr_mem_req_t       mem_req_o,
  input  logic [rsfr_pkg::BYTE_W-1:0]   mem_rdata_i
);
  import rsfr_pkg::*;

  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

  logic [TICK_W-1:0] ticks_q;
  logic [1:0]        mode_q, mode_d;
  logic [CW-1:0]     wr_cnt_q, wr_cnt_d;
  logic [TICK_W-1:0] sil_cnt_q, sil_cnt_d;
  logic              run_q, run_d;

  logic              emit_q, emit_d;
  logic [CW-1:0]     len_q, len_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              infl_q;
  logic [CW-1:0]     infl_idx_q;

  logic              ov_q;
  logic [BYTE_W-1:0] ob_q;
  logic [CW-1:0]     oidx_q;
  logic [CW-1:0]     olen_q;
  logic              olast_q;

  logic              in_acc;
  logic              rd_en;
  logic [TICK_W-1:0] sil_inc;

  assign in_ready_o = !emit_q;
  assign in_acc     = in_valid_i && in_ready_o;
  // next read only when the output register is sure to be free
  assign rd_en      = emit_q && !infl_q && (!ov_q || out_ready_i);
  assign sil_inc    = (sil_cnt_q == '1) ? sil_cnt_q : sil_cnt_q + TICK_W'(1);

  always_comb begin
    mode_d    = mode_q;
    wr_cnt_d  = wr_cnt_q;
    sil_cnt_d = sil_cnt_q;
    run_d     = run_q;
    emit_d    = emit_q;
    len_d     = len_q;
    rd_idx_d  = rd_idx_q;

    mem_req_o         = '0;
    mem_req_o.wr_data = rx_byte_i;
    mem_req_o.rd_en   = rd_en;
    mem_req_o.rd_addr = IDX_W'(rd_idx_q);

    if (in_acc) begin
      if (!cmd_i) begin
        if (!tx_busy_i) begin
          case (mode_q)
            MODE_IDLE: begin
              mem_req_o.wr_en   = 1'b1;
              mem_req_o.wr_addr = '0;
              wr_cnt_d          = CW'(1);
              mode_d            = MODE_RECV;
            end
            MODE_RECV: begin
              if (wr_cnt_q < CW'(FRAME_BYTES)) begin
                mem_req_o.wr_en   = 1'b1;
                mem_req_o.wr_addr = IDX_W'(wr_cnt_q);
                wr_cnt_d          = wr_cnt_q + CW'(1);
              end else begin
                mode_d = MODE_ERROR;
              end
            end
            default: begin
            end
          endcase
          sil_cnt_d = '0;
          run_d     = 1'b1;
        end
      end else if (run_q) begin
        if (sil_inc >= ticks_q) begin
          // silence expired: close out the current mode
          run_d     = 1'b0;
          sil_cnt_d = '0;
          if (mode_q == MODE_RECV) begin
            emit_d   = 1'b1;
            len_d    = wr_cnt_q;
            rd_idx_d = '0;
          end
          mode_d = MODE_IDLE;
        end else begin
          sil_cnt_d = sil_inc;
        end
      end
    end

    if (rd_en) begin
      rd_idx_d = rd_idx_q + CW'(1);
      if (rd_idx_q + CW'(1) == len_q) begin
        emit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q   <= TICKS_RESET;
      mode_q    <= MODE_INIT;
      wr_cnt_q  <= '0;
      sil_cnt_q <= '0;
      run_q     <= 1'b1;
      emit_q    <= 1'b0;
      len_q     <= '0;
      rd_idx_q  <= '0;
      infl_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_silence_ticks_i;
      end
      mode_q    <= mode_d;
      wr_cnt_q  <= wr_cnt_d;
      sil_cnt_q <= sil_cnt_d;
      run_q     <= run_d;
      emit_q    <= emit_d;
      len_q     <= len_d;
      rd_idx_q  <= rd_idx_d;
      infl_q    <= rd_en;
      if (infl_q) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      infl_idx_q <= rd_idx_q;
    end
    if (infl_q) begin
      ob_q    <= mem_rdata_i;
      oidx_q  <= infl_idx_q;
      olen_q  <= len_q;
      olast_q <= (infl_idx_q + CW'(1)) == len_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign frame_byte_o   = ob_q;
  assign byte_index_o   = IDX_W'(oidx_q);
  assign frame_length_o = LEN_W'(olen_q);
  assign frame_last_o   = olast_q;

endmodule

// ===== src/rtu_silence_frame_receiver.sv =====
`timescale 1ns / 1ps
// channel | signals                                         | direction
// in      | in_valid_i/in_ready_o, cmd_i, rx_byte_i, tx_busy_i | request in
// out     | out_valid_o/out_ready_i, frame_byte_o, byte_index_o,
//         | frame_length_o, frame_last_o                    | request out
// cfg     | cfg_we_i, cfg_silence_ticks_i                   | write only
//
// a byte or tick request is taken with in_ready_o; any store write happens then
// an expiry that closes a frame walks the store, reading a byte only after the
// last byte has left the frame memory's read register for the output register
// in_ready_o is low while the walk is reading; the last byte may still wait
// no clearing pass after reset: only bytes of the current frame are read out
module rtu_silence_frame_receiver #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsfr_pkg::TICK_W-1:0]   cfg_silence_ticks_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [rsfr_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                          tx_busy_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rsfr_pkg::BYTE_W-1:0]   frame_byte_o,
  output logic [rsfr_pkg::IDX_W-1:0]    byte_index_o,
  output logic [rsfr_pkg::LEN_W-1:0]    frame_length_o,
  output logic                          frame_last_o
);
  import rsfr_pkg::*;

  rsfr_mem_req_t     mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  rsfr_store #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rsfr_ctrl #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_silence_ticks_i (cfg_silence_ticks_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cmd_i               (cmd_i),
    .rx_byte_i           (rx_byte_i),
    .tx_busy_i           (tx_busy_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .frame_byte_o        (frame_byte_o),
    .byte_index_o        (byte_index_o),
    .frame_length_o      (frame_length_o),
    .frame_last_o        (frame_last_o),
    .mem_req_o           (mem_req),
    .mem_rdata_i         (mem_rdata)
  );

endmodule

// ===== src/rsfr_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rsfr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [rsfr_pkg::IDX_W-1:0]  byte_index_o,
  input logic [rsfr_pkg::LEN_W-1:0]  frame_length_o,
  input logic                        frame_last_o
);
  import rsfr_pkg::*;

  `RSFR_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i)
  `RSFR_ASSERT(a_len_nonzero, clk_i, rst_ni, out_valid_o |-> frame_length_o != '0)
  `RSFR_ASSERT(a_last_pos, clk_i, rst_ni, out_valid_o && frame_last_o |-> (LEN_W'(byte_index_o) + LEN_W'(1)) == frame_length_o)
  `RSFR_ASSERT(a_mid_pos, clk_i, rst_ni, out_valid_o && !frame_last_o |-> (LEN_W'(byte_index_o) + LEN_W'(1)) < frame_length_o)

endmodule

bind rtu_silence_frame_receiver rsfr_checker u_rsfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .byte_index_o   (byte_index_o),
  .frame_length_o (frame_length_o),
  .frame_last_o   (frame_last_o)
);
